>>> rtl/ecc_pkg.sv
// Shared types, constants and codes of the elevator car controller.
`timescale 1ns / 1ps

package ecc_pkg;

	// Car and floor limits.
	localparam int FLOOR_COUNT = 4;
	localparam int HEIGHT_REGS = 4;
	localparam int MAX_SERVED  = (FLOOR_COUNT < HEIGHT_REGS) ? FLOOR_COUNT : HEIGHT_REGS;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FLOORS_IN_USE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_0      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_1      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_2      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_3      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CAR_SPEED     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_WAIT     = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_DOOR_TIMEOUT  = 3'd7;

	// Configuration reset values.
	localparam logic [2:0]  RST_FLOORS_IN_USE = 3'd3;
	localparam logic [15:0] RST_HEIGHT_0      = 16'd0;
	localparam logic [15:0] RST_HEIGHT_1      = 16'd400;
	localparam logic [15:0] RST_HEIGHT_2      = 16'd800;
	localparam logic [15:0] RST_HEIGHT_3      = 16'd1200;
	localparam logic [9:0]  RST_CAR_SPEED     = 10'd50;
	localparam logic [15:0] RST_DOOR_WAIT     = 16'd3000;
	localparam logic [15:0] RST_DOOR_TIMEOUT  = 16'd5000;

	// Travel time arithmetic: distance (16 bits) times 1000 fits in 26 bits.
	localparam int DIST_W   = 16;
	localparam int DVS_W    = 10;
	localparam int DVD_W    = 26;
	localparam int DIV_CNT_W = $clog2(DVD_W);
	localparam logic [DVS_W-1:0] MS_PER_S = 10'd1000;

	// Door status word that means closed.
	localparam logic [15:0] DOOR_CLOSED_WORD = 16'd1;

	// Car phase codes as seen on the result.
	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_MOVING  = 3'd1,
		PH_ARRIVED = 3'd2,
		PH_WAIT    = 3'd3,
		PH_CHECK   = 3'd4
	} phase_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		C_IDLE,
		C_EVAL,
		C_MUL,
		C_DIV,
		C_OUT
	} ctl_state_t;

	// One control tick.
	typedef struct packed {
		logic        cmd;
		logic [31:0] time_ms;
		logic [3:0]  cabin_call_set;
		logic [3:0]  hall_call_set;
		logic        door_reading_valid;
		logic [15:0] door_reading;
	} tick_t;

	// One result.
	typedef struct packed {
		logic       motor_on;
		logic       motor_up;
		logic       door_open_pulse;
		logic       door_poll_pulse;
		logic       door_timeout_flag;
		logic [2:0] floor_now;
		logic [2:0] floor_target;
		logic       door_shut;
		logic [2:0] phase;
		logic [3:0] cabin_calls_pending;
		logic [3:0] hall_calls_pending;
	} result_t;

	// Commands from the sequencer to the datapath.
	typedef struct packed {
		logic tick_ready;
		logic capture;
		logic eval;
		logic div_start;
		logic travel_load;
		logic out_load;
	} ecc_cmd_t;

	// Status from the datapath to the sequencer.
	typedef struct packed {
		logic departing;
		logic div_done;
		logic out_free;
	} ecc_status_t;

endpackage

>>> rtl/ecc_if.sv
// Handshake interfaces for the tick and result channels.
`timescale 1ns / 1ps

interface ecc_tick_if import ecc_pkg::*;;
	logic  valid;
	logic  ready;
	tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ecc_result_if import ecc_pkg::*;;
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/elevator_car_controller.sv
// Elevator car controller top level: sequencer, datapath and assertions.
//
//   channel  | direction | carries
//   ---------+-----------+---------------------------------------------
//   tick     | in        | one control tick per transaction
//   result   | out       | one result transaction per tick
//   cfg_*    | in        | register write: enable, index, 16-bit data
//
// A tick that starts a trip gets its result only after the restoring divider
// has computed the travel time (one quotient bit per cycle); any other tick
// goes from evaluation straight to the result. One tick is worked on at a time.
// A finished result waits in the output register while the next tick is taken.
// Reset is asynchronous, active low, and puts the car idle at floor 1.
`timescale 1ns / 1ps

module elevator_car_controller import ecc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	ecc_tick_if.sink              tick,
	ecc_result_if.source          result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ecc_cmd_t    cmd;
	ecc_status_t st;

	// Sequencer.
	ecc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.st         (st),
		.cmd        (cmd)
	);

	// Datapath.
	ecc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.tick_data    (tick.data),
		.result_ready (result.ready),
		.result_valid (result.valid),
		.result_data  (result.data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	assign tick.ready = cmd.tick_ready;

`ifndef SYNTHESIS
	// A tick in flight blocks the next transaction.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(tick.valid && tick.ready) |=> !tick.ready)
		else $error("tick accepted while another is in flight");

	// A new result never overwrites one that has not been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!result.valid || result.ready))
		else $error("result register overwritten");

	// While moving the motor runs toward a real target.
	a_moving_motor: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.phase == PH_MOVING)
			|-> (result.data.motor_on && result.data.floor_target != 3'd0))
		else $error("moving phase without motor or target");

	// Division only finishes while the sequencer waits for it.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !st.div_done)
		else $error("divider finished too early");
`endif

endmodule

>>> rtl/ecc_div.sv
// Restoring divider, one quotient bit per cycle, for the travel time.
`timescale 1ns / 1ps

module ecc_div import ecc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0]     quo_q;
	logic [DVS_W-1:0]     rem_q;
	logic [DVS_W-1:0]     dvs_q;
	logic [DVS_W:0]       rem_sh;
	logic                 fits;
	logic [DVS_W:0]       rem_sub;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	always_comb begin
		rem_sh  = {rem_q, quo_q[DVD_W-1]};
		fits    = (rem_sh >= {1'b0, dvs_q});
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	// Control: iteration count and completion strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Data: the dividend register turns into the quotient bit by bit.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DVD_W-2:0], fits};
			rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/ecc_ctrl.sv
// Sequencer for one tick: capture, evaluate, travel time division, result.
`timescale 1ns / 1ps

module ecc_ctrl import ecc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tick_valid,
	input  ecc_status_t st,
	output ecc_cmd_t    cmd
);

	ctl_state_t state_q;
	ctl_state_t state_nx;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Next state and commands.
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			C_IDLE: begin
				cmd.tick_ready = 1'b1;
				if (tick_valid) begin
					cmd.capture = 1'b1;
					state_nx    = C_EVAL;
				end
			end
			C_EVAL: begin
				cmd.eval = 1'b1;
				state_nx = st.departing ? C_MUL : C_OUT;
			end
			C_MUL: begin
				cmd.div_start = 1'b1;
				state_nx      = C_DIV;
			end
			C_DIV: begin
				if (st.div_done) begin
					cmd.travel_load = 1'b1;
					state_nx        = C_OUT;
				end
			end
			C_OUT: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = C_IDLE;
				end
			end
			default: state_nx = C_IDLE;
		endcase
	end

endmodule

>>> rtl/ecc_dp.sv
// Datapath: configuration, car state, tick evaluation and result register.
`timescale 1ns / 1ps

module ecc_dp import ecc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ecc_cmd_t              cmd,
	output ecc_status_t           st,
	input  tick_t                 tick_data,
	input  logic                  result_ready,
	output logic                  result_valid,
	output result_t               result_data,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Configuration registers.
	logic [2:0]       floors_q;
	logic [15:0]      height_q [HEIGHT_REGS];
	logic [DVS_W-1:0] speed_q;
	logic [15:0]      door_wait_q;
	logic [15:0]      door_tmo_q;

	// Car state.
	phase_t           phase_q;
	logic [31:0]      phase_start_q;
	logic [31:0]      move_start_q;
	logic [DVD_W-1:0] travel_q;
	logic [15:0]      pos_q;
	logic [2:0]       floor_q;
	logic [2:0]       target_q;
	logic [3:0]       cabin_q;
	logic [3:0]       hall_q;
	logic             door_closed_q;
	logic             motor_on_q;
	logic             motor_up_q;

	// Per-tick registers.
	tick_t            item_q;
	logic             open_q;
	logic             poll_q;
	logic             tmo_q;
	logic [DIST_W-1:0] dist_q;
	logic [DVS_W-1:0] divisor_q;
	logic             res_valid_q;
	result_t          res_q;

	// Evaluation results.
	phase_t           nx_phase;
	logic [31:0]      nx_phase_start;
	logic [31:0]      nx_move_start;
	logic [15:0]      nx_pos;
	logic [2:0]       nx_floor;
	logic [2:0]       nx_target;
	logic [3:0]       nx_cabin;
	logic [3:0]       nx_hall;
	logic             nx_door_closed;
	logic             nx_motor_on;
	logic             nx_motor_up;
	logic             nx_open;
	logic             nx_poll;
	logic             nx_tmo;
	logic             departing;
	logic [DIST_W-1:0] nx_dist;

	logic [2:0]       served;
	logic [3:0]       served_mask;
	logic [3:0]       cabin_m;
	logic [3:0]       hall_m;
	logic [2:0]       pick_cabin;
	logic [2:0]       pick_hall;
	logic [2:0]       pick;
	logic [2:0]       hsel;
	logic [15:0]      hsel_height;
	logic [3:0]       clr_bit;
	logic             door_ok;
	logic [31:0]      move_elapsed;
	logic [31:0]      phase_elapsed;
	logic [DVD_W-1:0] div_quotient;
	logic             div_done;
	logic [DVD_W-1:0] dividend;

	// Lowest pending call among the served floors, never the current floor.
	function automatic logic [2:0] pick_call(input logic [3:0] mask, input logic [2:0] n,
			input logic [2:0] fl);
		logic [2:0] res;
		res = '0;
		for (int i = MAX_SERVED - 1; i >= 0; i--) begin
			if (3'(i) < n && mask[i] && 3'(i + 1) != fl) begin
				res = 3'(i + 1);
			end
		end
		return res;
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floors_q    <= RST_FLOORS_IN_USE;
			height_q[0] <= RST_HEIGHT_0;
			height_q[1] <= RST_HEIGHT_1;
			height_q[2] <= RST_HEIGHT_2;
			height_q[3] <= RST_HEIGHT_3;
			speed_q     <= RST_CAR_SPEED;
			door_wait_q <= RST_DOOR_WAIT;
			door_tmo_q  <= RST_DOOR_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FLOORS_IN_USE: floors_q    <= cfg_data[2:0];
				CFG_HEIGHT_0:      height_q[0] <= cfg_data;
				CFG_HEIGHT_1:      height_q[1] <= cfg_data;
				CFG_HEIGHT_2:      height_q[2] <= cfg_data;
				CFG_HEIGHT_3:      height_q[3] <= cfg_data;
				CFG_CAR_SPEED:     speed_q     <= cfg_data[DVS_W-1:0];
				CFG_DOOR_WAIT:     door_wait_q <= cfg_data;
				CFG_DOOR_TIMEOUT:  door_tmo_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Served floors and merged call masks.
	always_comb begin
		served = (floors_q > 3'(MAX_SERVED)) ? 3'(MAX_SERVED) : floors_q;
		for (int i = 0; i < 4; i++) begin
			served_mask[i] = (3'(i) < served);
		end
		cabin_m    = cabin_q | (item_q.cabin_call_set & served_mask);
		hall_m     = hall_q | (item_q.hall_call_set & served_mask);
		pick_cabin = pick_call(cabin_m, served, floor_q);
		pick_hall  = pick_call(hall_m, served, floor_q);
		pick       = (pick_cabin != '0) ? pick_cabin : pick_hall;
		door_ok    = item_q.door_reading_valid && (item_q.door_reading == DOOR_CLOSED_WORD);
		move_elapsed  = item_q.time_ms - move_start_q;
		phase_elapsed = item_q.time_ms - phase_start_q;
	end

	// One height read: the target on arrival, the picked floor on departure.
	always_comb begin
		hsel = (phase_q == PH_MOVING) ? target_q : pick;
		if (hsel != '0 && hsel <= 3'(HEIGHT_REGS)) begin
			hsel_height = height_q[2'(hsel - 3'd1)];
		end else begin
			hsel_height = '0;
		end
		if (floor_q != '0 && floor_q <= 3'd4) begin
			clr_bit = 4'd1 << 2'(floor_q - 3'd1);
		end else begin
			clr_bit = '0;
		end
	end

	// Phase machine step for the captured tick.
	always_comb begin
		nx_phase       = phase_q;
		nx_phase_start = phase_start_q;
		nx_move_start  = move_start_q;
		nx_pos         = pos_q;
		nx_floor       = floor_q;
		nx_target      = target_q;
		nx_cabin       = cabin_m;
		nx_hall        = hall_m;
		nx_door_closed = door_closed_q;
		nx_motor_on    = motor_on_q;
		nx_motor_up    = motor_up_q;
		nx_open        = 1'b0;
		nx_poll        = 1'b0;
		nx_tmo         = 1'b0;
		departing      = 1'b0;
		nx_dist        = (pos_q > hsel_height) ? pos_q - hsel_height : hsel_height - pos_q;
		case (phase_q)
			PH_MOVING: begin
				if (move_elapsed >= 32'(travel_q)) begin
					nx_motor_on = 1'b0;
					nx_floor    = target_q;
					nx_pos      = hsel_height;
					nx_phase    = PH_ARRIVED;
				end
			end
			PH_ARRIVED: begin
				nx_open        = 1'b1;
				nx_door_closed = 1'b0;
				nx_phase_start = item_q.time_ms;
				nx_phase       = PH_WAIT;
			end
			PH_WAIT: begin
				if (phase_elapsed > 32'(door_wait_q)) begin
					nx_phase       = PH_CHECK;
					nx_phase_start = item_q.time_ms;
				end
			end
			PH_CHECK: begin
				nx_poll = 1'b1;
				if (phase_elapsed > 32'(door_tmo_q) || door_ok) begin
					nx_tmo         = (phase_elapsed > 32'(door_tmo_q));
					nx_cabin       = cabin_m & ~clr_bit;
					nx_hall        = hall_m & ~clr_bit;
					nx_door_closed = 1'b1;
					nx_phase       = PH_IDLE;
				end
			end
			default: begin
				nx_phase  = PH_IDLE;
				nx_target = pick;
				if (pick != '0) begin
					departing     = 1'b1;
					nx_move_start = item_q.time_ms;
					nx_motor_up   = !(hsel_height < pos_q);
					nx_motor_on   = 1'b1;
					nx_floor      = pick;
					nx_phase      = PH_MOVING;
				end
			end
		endcase
	end

	// Control state of the car.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			phase_start_q <= '0;
			move_start_q  <= '0;
			travel_q      <= '0;
			pos_q         <= RST_HEIGHT_0;
			floor_q       <= 3'd1;
			target_q      <= '0;
			cabin_q       <= '0;
			hall_q        <= '0;
			door_closed_q <= 1'b1;
			motor_on_q    <= 1'b0;
			motor_up_q    <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cmd.eval) begin
				phase_q       <= nx_phase;
				phase_start_q <= nx_phase_start;
				move_start_q  <= nx_move_start;
				pos_q         <= nx_pos;
				floor_q       <= nx_floor;
				target_q      <= nx_target;
				cabin_q       <= nx_cabin;
				hall_q        <= nx_hall;
				door_closed_q <= nx_door_closed;
				motor_on_q    <= nx_motor_on;
				motor_up_q    <= nx_motor_up;
			end
			if (cmd.travel_load) begin
				travel_q <= div_quotient;
			end
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Captured transaction, pulses, divider operands and result payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= tick_data;
		end
		if (cmd.eval) begin
			open_q    <= nx_open;
			poll_q    <= nx_poll;
			tmo_q     <= nx_tmo;
			dist_q    <= nx_dist;
			divisor_q <= (speed_q == '0) ? DVS_W'(1) : speed_q;
		end
		if (cmd.out_load) begin
			res_q.motor_on            <= motor_on_q;
			res_q.motor_up            <= motor_up_q;
			res_q.door_open_pulse     <= open_q;
			res_q.door_poll_pulse     <= poll_q;
			res_q.door_timeout_flag   <= tmo_q;
			res_q.floor_now           <= floor_q;
			res_q.floor_target        <= target_q;
			res_q.door_shut           <= door_closed_q;
			res_q.phase               <= phase_q;
			res_q.cabin_calls_pending <= cabin_q;
			res_q.hall_calls_pending  <= hall_q;
		end
	end

	// Travel time = distance * 1000 / speed.
	assign dividend = DVD_W'(dist_q) * DVD_W'(MS_PER_S);

	ecc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (divisor_q),
		.done     (div_done),
		.quotient (div_quotient)
	);

	assign st.departing = departing;
	assign st.div_done  = div_done;
	assign st.out_free  = !res_valid_q || result_ready;

	assign result_valid = res_valid_q;
	assign result_data  = res_q;

endmodule
